FILE: hw/rtl/clst_pkg.sv
// shared types, codes and sizing helpers for the compacting list store
package clst_pkg;

   localparam int CAPACITY_DEFAULT   = 64;
   localparam int ELEM_WIDTH_DEFAULT = 32;

   // request codes
   localparam logic [1:0] REQ_PUSH   = 2'd0;
   localparam logic [1:0] REQ_POP    = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;
   localparam logic [1:0] REQ_REMOVE = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   // fan-in of each read tree node
   localparam int TREE_FAN = 8;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [5:0]  position;
      logic [31:0] push_value;
   } req_type_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic [6:0]  count;
      logic [1:0]  status;
   } rsp_type;

   // per-cycle command broadcast to every cell, already qualified by range checks
   typedef struct packed {
      logic push;
      logic pop;
      logic read;
      logic remove;
   } cmd_type;

   // registered levels of an 8-way tree over n leaves (three index bits per level)
   function automatic int tree_levels(input int n);
      return ($clog2(n) + 2) / 3;
   endfunction

endpackage

FILE: hw/rtl/clst_cell.sv
// one list entry: holds a value, loads on push, takes its right neighbor on remove
module clst_cell #(
   parameter int INDEX      = 0,
   parameter int CNT_W      = 7,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                  clock,
   input  clst_pkg::cmd_type     cmd,
   input  logic [CNT_W-1:0]      count,
   input  logic [CNT_W-1:0]      last_idx,
   input  logic [CNT_W-1:0]      pos,
   input  logic [ELEM_WIDTH-1:0] push_elem,
   input  logic [ELEM_WIDTH-1:0] next_data,
   output logic [ELEM_WIDTH-1:0] data,
   output logic [ELEM_WIDTH-1:0] read_data
);

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

   logic [ELEM_WIDTH-1:0] data_ff;
   logic [ELEM_WIDTH-1:0] data_in;
   logic                  hit;

   always_comb begin
      data_in = data_ff;
      priority if (cmd.push && count == MY_IDX) begin
         data_in = push_elem;
      end else if (cmd.remove && MY_IDX >= pos) begin
         // everything from the removed place upward moves down one
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign hit       = (cmd.pop && last_idx == MY_IDX) || (cmd.read && pos == MY_IDX);
   assign read_data = hit ? data_ff : '0;
   assign data      = data_ff;

endmodule

FILE: hw/rtl/clst_or_tree.sv
// registered 8-way or tree that collects the one selected cell value
module clst_or_tree #(
   parameter int N = 64,
   parameter int W = 32
) (
   input  logic                clock,
   input  logic [N-1:0][W-1:0] leaf,
   output logic [W-1:0]        root
);

   localparam int FAN    = clst_pkg::TREE_FAN;
   localparam int LEVELS = clst_pkg::tree_levels(N);

   logic [W-1:0] node [LEVELS+1][N];

   for (genvar j = 0; j < N; j++) begin : g_leaf
      assign node[0][j] = leaf[j];
   end

   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      localparam int PREV = (N + FAN**l - 1) / (FAN**l);
      localparam int CNT  = (N + FAN**(l+1) - 1) / (FAN**(l+1));
      for (genvar j = 0; j < CNT; j++) begin : g_node
         logic [W-1:0] child [FAN];
         logic [W-1:0] node_in;
         logic [W-1:0] node_ff;
         for (genvar k = 0; k < FAN; k++) begin : g_child
            if (j * FAN + k < PREV) begin : g_real
               assign child[k] = node[l][j*FAN+k];
            end else begin : g_pad
               assign child[k] = '0;
            end
         end
         always_comb begin
            node_in = '0;
            for (int k = 0; k < FAN; k++) begin
               node_in = node_in | child[k];
            end
         end
         always_ff @(posedge clock) begin
            node_ff <= node_in;
         end
         assign node[l+1][j] = node_ff;
      end
   end

   assign root = node[LEVELS][0];

endmodule

FILE: hw/rtl/compacting_list_store.sv
// top level of the compacting list store: cell row, read tree and handshake control
// results: pop and read data are gathered by the registered 8-way or tree and then registered
//   into the response once a wait counter loaded on accept has counted down through the tree
// the input is stalled while a result is in the tree or held by rsp_stall; items never overlap
// push and remove update cells in the cycle the item is accepted; pop alters only the count
// reset clears the entry count and the handshake and stalls the input; entries keep their data
module compacting_list_store #(
   parameter int CAPACITY   = clst_pkg::CAPACITY_DEFAULT,
   parameter int ELEM_WIDTH = clst_pkg::ELEM_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  clst_pkg::req_type_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output clst_pkg::rsp_type     rsp_payload
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > 6) ? CNT_W : 6;
   localparam int LEVELS = clst_pkg::tree_levels(CAPACITY);
   localparam int WAIT_W = $clog2(LEVELS + 1);
   localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(CAPACITY);
   localparam logic [WAIT_W-1:0] WAIT_LOAD  = WAIT_W'(LEVELS);
   localparam logic [WAIT_W-1:0] WAIT_LAST  = WAIT_W'(1);

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [WAIT_W-1:0] wait_ff;
   logic [WAIT_W-1:0] wait_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   clst_pkg::rsp_type rsp_ff;
   clst_pkg::rsp_type rsp_in;

   logic              accept;
   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  count_ext;
   logic              pos_ok;
   logic              is_full;
   logic              is_empty;
   logic [1:0]        status;
   clst_pkg::cmd_type cmd;
   logic [CNT_W-1:0]  last_idx;
   logic [CNT_W-1:0]  pos_cell;
   logic [ELEM_WIDTH-1:0] push_elem;
   logic [ELEM_WIDTH-1:0] tree_value;
   logic [31:0]           tree_value32;
   logic [ELEM_WIDTH-1:0] cell_data [CAPACITY+1];
   logic [CAPACITY-1:0][ELEM_WIDTH-1:0] cell_read;

   assign accept    = req_valid && !req_stall;
   assign req_stall = reset || (wait_ff != '0) || (rsp_valid_ff && rsp_stall);

   assign pos_ext   = CMP_W'(req_payload.position);
   assign count_ext = CMP_W'(count_ff);
   assign pos_ok    = pos_ext < count_ext;
   assign is_full   = count_ff == FULL_COUNT;
   assign is_empty  = count_ff == '0;
   assign last_idx  = count_ff - CNT_W'(1);
   // only used when the position is known to be below the count
   assign pos_cell  = pos_ext[CNT_W-1:0];

   always_comb begin
      cmd      = '0;
      count_in = count_ff;
      status   = clst_pkg::ST_OK;
      unique case (req_payload.req_type)
         clst_pkg::REQ_PUSH: begin
            if (is_full) begin
               status = clst_pkg::ST_FULL;
            end else begin
               cmd.push = accept;
               count_in = count_ff + CNT_W'(1);
            end
         end
         clst_pkg::REQ_POP: begin
            if (is_empty) begin
               status = clst_pkg::ST_EMPTY;
            end else begin
               cmd.pop  = accept;
               count_in = last_idx;
            end
         end
         clst_pkg::REQ_READ: begin
            if (!pos_ok) begin
               status = clst_pkg::ST_RANGE;
            end else begin
               cmd.read = accept;
            end
         end
         clst_pkg::REQ_REMOVE: begin
            if (!pos_ok) begin
               status = clst_pkg::ST_RANGE;
            end else begin
               cmd.remove = accept;
               count_in   = last_idx;
            end
         end
         default: begin
            status = clst_pkg::ST_OK;
         end
      endcase
   end

   if (ELEM_WIDTH >= 32) begin : g_wide
      assign push_elem    = ELEM_WIDTH'(req_payload.push_value);
      assign tree_value32 = tree_value[31:0];
   end else begin : g_narrow
      assign push_elem    = req_payload.push_value[ELEM_WIDTH-1:0];
      assign tree_value32 = 32'(tree_value);
   end

   assign cell_data[CAPACITY] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      clst_cell #(
         .INDEX      (i),
         .CNT_W      (CNT_W),
         .ELEM_WIDTH (ELEM_WIDTH)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .count     (count_ff),
         .last_idx  (last_idx),
         .pos       (pos_cell),
         .push_elem (push_elem),
         .next_data (cell_data[i+1]),
         .data      (cell_data[i]),
         .read_data (cell_read[i])
      );
   end

   clst_or_tree #(
      .N (CAPACITY),
      .W (ELEM_WIDTH)
   ) u_tree (
      .clock (clock),
      .leaf  (cell_read),
      .root  (tree_value)
   );

   always_comb begin
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         wait_in        = WAIT_LOAD;
         rsp_in.count   = 7'(count_in);
         rsp_in.status  = status;
      end else if (wait_ff != '0) begin
         wait_in = wait_ff - WAIT_W'(1);
         if (wait_ff == WAIT_LAST) begin
            // tree root now holds the selected value, or zero when nothing was read
            rsp_in.read_value = tree_value32;
            rsp_valid_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> !rsp_valid_ff && wait_ff == WAIT_LOAD)
      else $error("result not pending after accepted item");

   a_rsp_from_tree: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(wait_ff) == WAIT_LAST)
      else $error("result raised without tree drain");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == clst_pkg::ST_FULL |-> count_ff == FULL_COUNT)
      else $error("full status while list not full");

endmodule
